// ===== sv/iies_pkg.sv =====
// ----------------------------------------------------------------------------
// iies_pkg
// Shared types and constants for the impact event scorer: payload structs,
// register indexes, report codes and the fixed-point severity constants.
// ----------------------------------------------------------------------------
package iies_pkg;

    // input sample and result report
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [31:0] time_ms;
    } iies_in_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] duration_ms;
        logic [15:0] peak_accel;
        logic [15:0] peak_gyro;
        logic [9:0]  severity_tenths;
        logic [1:0]  severity_class;
    } iies_out_t;

    // lane to merge stage
    typedef struct packed {
        logic        done;
        logic [15:0] mag;
    } iies_lane_out_t;

    // scorer to control
    typedef struct packed {
        logic       done;
        logic [9:0] tenths;
        logic [1:0] sclass;
    } iies_score_out_t;

    // report kinds
    localparam logic [1:0] KIND_STARTED  = 2'd0;
    localparam logic [1:0] KIND_IGNORED  = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    // severity classes
    localparam logic [1:0] CLASS_MINOR     = 2'd0;
    localparam logic [1:0] CLASS_MODERATE  = 2'd1;
    localparam logic [1:0] CLASS_CHECK     = 2'd2;
    localparam logic [1:0] CLASS_EMERGENCY = 2'd3;

    // register indexes
    localparam logic [2:0] REG_START_ACCEL = 3'd0;
    localparam logic [2:0] REG_START_GYRO  = 3'd1;
    localparam logic [2:0] REG_QUIET_ACCEL = 3'd2;
    localparam logic [2:0] REG_QUIET_GYRO  = 3'd3;
    localparam logic [2:0] REG_QUIET_HOLD  = 3'd4;
    localparam logic [2:0] REG_MIN_EVENT   = 3'd5;

    // register reset values
    localparam logic [15:0] RST_START_ACCEL = 16'd2048;
    localparam logic [15:0] RST_START_GYRO  = 16'd2048;
    localparam logic [15:0] RST_QUIET_ACCEL = 16'd192;
    localparam logic [15:0] RST_QUIET_GYRO  = 16'd154;
    localparam logic [15:0] RST_QUIET_HOLD  = 16'd450;
    localparam logic [15:0] RST_MIN_EVENT   = 16'd100;

    // gravity, 9.81 m/s^2 at 1/128 m/s^2
    localparam logic [15:0] GRAVITY_UNITS = 16'd1256;

    // severity ramps
    localparam logic [15:0] RAMP_A_LO   = 16'd2048;
    localparam logic [15:0] RAMP_A_SPAN = 16'd3712;
    localparam logic [15:0] RAMP_G_LO   = 16'd2048;
    localparam logic [15:0] RAMP_G_SPAN = 16'd3072;
    localparam logic [31:0] RAMP_D_LO   = 32'd120;
    localparam logic [31:0] RAMP_D_SPAN = 32'd1080;

    // weights over a common denominator of 2^20 * 27 * 841
    localparam logic [20:0] SEV_CA  = 21'd1123200;
    localparam logic [19:0] SEV_CG  = 20'd630750;
    localparam logic [31:0] SEV_CD  = 32'd2204631040;

    // ceil(2^40 / (27 * 841)): exact floor divide for numerators below 2^25
    localparam logic [25:0] SEV_RECIP = 26'd48421704;

    localparam logic [9:0] SEV_MAX       = 10'd1000;
    localparam logic [9:0] SEV_EMERGENCY = 10'd800;
    localparam logic [9:0] SEV_CHECK     = 10'd600;
    localparam logic [9:0] SEV_MODERATE  = 10'd300;

endpackage

// ===== sv/iies_lane.sv =====
// ----------------------------------------------------------------------------
// iies_lane
// Vector magnitude lane: sums three squares with one multiplier, then takes
// the floor square root two radicand bits per cycle.
// ----------------------------------------------------------------------------
module iies_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [15:0]     comp_0,
    input  logic signed [15:0]     comp_1,
    input  logic signed [15:0]     comp_2,
    output iies_pkg::iies_lane_out_t lane_out
);

    localparam logic [4:0] STEP_LAST_SQ   = 5'd2;
    localparam logic [4:0] STEP_LAST_ROOT = 5'd18;

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         step_reg;
    logic signed [15:0] c0_reg, c1_reg, c2_reg;
    logic [31:0]        rad_reg;
    logic [16:0]        rem_reg;
    logic [15:0]        root_reg;

    logic [15:0] abs_v;
    logic [31:0] sq;
    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        take;

    // square of the component at the head of the shift line
    assign abs_v = c0_reg[15] ? 16'(-c0_reg) : 16'(c0_reg);
    assign sq    = abs_v * abs_v;

    // one root digit
    assign rem_sh = {rem_reg, rad_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = rem_sh >= trial;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == STEP_LAST_ROOT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            c0_reg   <= comp_0;
            c1_reg   <= comp_1;
            c2_reg   <= comp_2;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg <= STEP_LAST_SQ) begin
                rad_reg <= rad_reg + sq;
                c0_reg  <= c1_reg;
                c1_reg  <= c2_reg;
            end else begin
                rad_reg  <= {rad_reg[29:0], 2'b00};
                rem_reg  <= take ? 17'(rem_sh - trial) : 17'(rem_sh);
                root_reg <= {root_reg[14:0], take};
            end
        end
    end

    assign lane_out.done = done_reg;
    assign lane_out.mag  = root_reg;

endmodule

// ===== sv/iies_score.sv =====
// ----------------------------------------------------------------------------
// iies_score
// Severity unit: squared accel and gyro ramps and the linear duration ramp
// weighted over a common denominator, summed, then divided by that denominator through a reciprocal multiply.
// ----------------------------------------------------------------------------
module iies_score (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] peak_accel,
    input  logic [15:0] peak_gyro,
    input  logic [31:0] duration,
    output iies_pkg::iies_score_out_t score_out
);

    localparam logic [3:0] STEP_SQUARE = 4'd0;
    localparam logic [3:0] STEP_MUL_A  = 4'd1;
    localparam logic [3:0] STEP_MUL_G  = 4'd2;
    localparam logic [3:0] STEP_MUL_D  = 4'd3;
    localparam logic [3:0] STEP_SUM    = 4'd4;
    localparam logic [3:0] STEP_LAST   = 4'd5;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  step_reg;
    logic [11:0] ra_reg, rg_reg;
    logic [10:0] rd_reg;
    logic [23:0] a2_reg, g2_reg;
    logic [45:0] prod_reg;
    logic [45:0] num_reg;
    logic [9:0]  quo_reg;

    logic [11:0] ra, rg;
    logic [10:0] rd;
    logic [15:0] a_off, g_off;
    logic [31:0] d_off;
    logic [44:0] mul_a;
    logic [43:0] mul_g;
    logic [42:0] mul_d;
    logic [24:0] num_hi;
    logic [50:0] quo_prod;
    logic [9:0]  tenths;

    // clamped ramps
    assign a_off = peak_accel - iies_pkg::RAMP_A_LO;
    assign g_off = peak_gyro - iies_pkg::RAMP_G_LO;
    assign d_off = duration - iies_pkg::RAMP_D_LO;

    always_comb begin
        if (peak_accel <= iies_pkg::RAMP_A_LO) begin
            ra = '0;
        end else if (a_off >= iies_pkg::RAMP_A_SPAN) begin
            ra = 12'(iies_pkg::RAMP_A_SPAN);
        end else begin
            ra = 12'(a_off);
        end
        if (peak_gyro <= iies_pkg::RAMP_G_LO) begin
            rg = '0;
        end else if (g_off >= iies_pkg::RAMP_G_SPAN) begin
            rg = 12'(iies_pkg::RAMP_G_SPAN);
        end else begin
            rg = 12'(g_off);
        end
        if (duration <= iies_pkg::RAMP_D_LO) begin
            rd = '0;
        end else if (d_off >= iies_pkg::RAMP_D_SPAN) begin
            rd = 11'(iies_pkg::RAMP_D_SPAN);
        end else begin
            rd = 11'(d_off);
        end
    end

    // weighted terms
    assign mul_a = a2_reg * iies_pkg::SEV_CA;
    assign mul_g = g2_reg * iies_pkg::SEV_CG;
    assign mul_d = rd_reg * iies_pkg::SEV_CD;

    // drop the 2^20 factor, then multiply by the reciprocal of 27 * 841
    assign num_hi   = num_reg[44:20];
    assign quo_prod = num_hi * iies_pkg::SEV_RECIP;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            ra_reg <= ra;
            rg_reg <= rg;
            rd_reg <= rd;
        end else if (busy_reg) begin
            case (step_reg)
                STEP_SQUARE: begin
                    a2_reg <= ra_reg * ra_reg;
                    g2_reg <= rg_reg * rg_reg;
                end
                STEP_MUL_A: begin
                    prod_reg <= 46'(mul_a);
                    num_reg  <= '0;
                end
                STEP_MUL_G: begin
                    prod_reg <= 46'(mul_g);
                    num_reg  <= num_reg + prod_reg;
                end
                STEP_MUL_D: begin
                    prod_reg <= 46'(mul_d);
                    num_reg  <= num_reg + prod_reg;
                end
                STEP_SUM: begin
                    num_reg <= num_reg + prod_reg;
                end
                STEP_LAST: begin
                    // quotient is at most 1000, so ten bits above the shift
                    quo_reg <= quo_prod[49:40];
                end
                default: ;
            endcase
        end
    end

    // clamp and class
    assign tenths = (quo_reg > iies_pkg::SEV_MAX) ? iies_pkg::SEV_MAX : quo_reg;

    always_comb begin
        score_out.done   = done_reg;
        score_out.tenths = tenths;
        if (tenths >= iies_pkg::SEV_EMERGENCY) begin
            score_out.sclass = iies_pkg::CLASS_EMERGENCY;
        end else if (tenths >= iies_pkg::SEV_CHECK) begin
            score_out.sclass = iies_pkg::CLASS_CHECK;
        end else if (tenths >= iies_pkg::SEV_MODERATE) begin
            score_out.sclass = iies_pkg::CLASS_MODERATE;
        end else begin
            score_out.sclass = iies_pkg::CLASS_MINOR;
        end
    end

endmodule

// ===== sv/imu_impact_event_scorer_unit.sv =====
// ----------------------------------------------------------------------------
// imu_impact_event_scorer_unit
// Impact event detector and scorer for 6-axis motion samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time. The accel and gyro lanes run side by side,
// each forming the sum of squares and then the square root; the merge stage
// then gives a start, ignored or complete report or none, and a complete
// report also passes through the severity unit's squaring, weighting,
// summing and reciprocal multiply steps. A finished report sits in the
// output register while the next sample is taken; the block only waits
// when a new report is ready before the previous one has been transferred.
module imu_impact_event_scorer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iies_pkg::iies_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output iies_pkg::iies_out_t m_payload,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LANE   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SCORE  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] start_a_reg, start_g_reg, quiet_a_reg, quiet_g_reg, hold_reg, min_reg;
    logic        active_reg;
    logic [31:0] ev_start_reg, last_motion_reg;
    logic [15:0] peak_a_reg, peak_g_reg;
    logic [31:0] now_reg;
    logic        m_valid_reg;
    iies_pkg::iies_out_t m_data_reg, res_reg;

    iies_pkg::iies_lane_out_t  a_lane, g_lane;
    iies_pkg::iies_score_out_t score;

    logic        in_xfer;
    logic        score_go;
    logic [15:0] amag, gmag, adelta, hold;
    logic        start_hit, quiet;
    logic [15:0] pa_new, pg_new;
    logic [31:0] lm_new, elapsed, dur;
    logic        finish;
    logic        load_out;

    assign in_xfer = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // magnitude lanes
    iies_lane u_lane_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_xfer),
        .comp_0   (s_payload.accel_x),
        .comp_1   (s_payload.accel_y),
        .comp_2   (s_payload.accel_z),
        .lane_out (a_lane)
    );

    iies_lane u_lane_g (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_xfer),
        .comp_0   (s_payload.gyro_x),
        .comp_1   (s_payload.gyro_y),
        .comp_2   (s_payload.gyro_z),
        .lane_out (g_lane)
    );

    // merge: event decision
    assign amag      = a_lane.mag;
    assign gmag      = g_lane.mag;
    assign adelta    = (amag >= iies_pkg::GRAVITY_UNITS) ? amag - iies_pkg::GRAVITY_UNITS
                                                          : iies_pkg::GRAVITY_UNITS - amag;
    assign start_hit = (adelta > start_a_reg) || (gmag > start_g_reg);
    assign quiet     = (adelta < quiet_a_reg) && (gmag < quiet_g_reg);
    assign hold      = (hold_reg == '0) ? 16'd1 : hold_reg;
    assign pa_new    = (adelta > peak_a_reg) ? adelta : peak_a_reg;
    assign pg_new    = (gmag > peak_g_reg) ? gmag : peak_g_reg;
    assign lm_new    = quiet ? last_motion_reg : now_reg;
    assign elapsed   = now_reg - lm_new;
    assign finish    = elapsed >= {16'd0, hold};
    assign dur       = now_reg - ev_start_reg;
    assign score_go  = (state_reg == ST_DECIDE) && active_reg && finish &&
                       (dur >= {16'd0, min_reg});

    // severity unit
    iies_score u_score (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (score_go),
        .peak_accel (pa_new),
        .peak_gyro  (pg_new),
        .duration   (dur),
        .score_out  (score)
    );

    // output register loads when free or being drained
    assign load_out = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_LANE;
                end
            end
            ST_LANE: begin
                if (a_lane.done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!active_reg) begin
                    state_next = start_hit ? ST_FINISH : ST_IDLE;
                end else if (!finish) begin
                    state_next = ST_IDLE;
                end else if (score_go) begin
                    state_next = ST_SCORE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCORE: begin
                if (score.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control, configuration and event state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            start_a_reg     <= iies_pkg::RST_START_ACCEL;
            start_g_reg     <= iies_pkg::RST_START_GYRO;
            quiet_a_reg     <= iies_pkg::RST_QUIET_ACCEL;
            quiet_g_reg     <= iies_pkg::RST_QUIET_GYRO;
            hold_reg        <= iies_pkg::RST_QUIET_HOLD;
            min_reg         <= iies_pkg::RST_MIN_EVENT;
            active_reg      <= 1'b0;
            ev_start_reg    <= '0;
            last_motion_reg <= '0;
            peak_a_reg      <= '0;
            peak_g_reg      <= '0;
        end else begin
            state_reg <= state_next;

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    iies_pkg::REG_START_ACCEL: start_a_reg <= cfg_wdata;
                    iies_pkg::REG_START_GYRO:  start_g_reg <= cfg_wdata;
                    iies_pkg::REG_QUIET_ACCEL: quiet_a_reg <= cfg_wdata;
                    iies_pkg::REG_QUIET_GYRO:  quiet_g_reg <= cfg_wdata;
                    iies_pkg::REG_QUIET_HOLD:  hold_reg    <= cfg_wdata;
                    iies_pkg::REG_MIN_EVENT:   min_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            if (state_reg == ST_DECIDE) begin
                if (!active_reg) begin
                    if (start_hit) begin
                        active_reg      <= 1'b1;
                        ev_start_reg    <= now_reg;
                        last_motion_reg <= now_reg;
                        peak_a_reg      <= adelta;
                        peak_g_reg      <= gmag;
                    end
                end else if (finish) begin
                    active_reg      <= 1'b0;
                    ev_start_reg    <= '0;
                    last_motion_reg <= '0;
                    peak_a_reg      <= '0;
                    peak_g_reg      <= '0;
                end else begin
                    last_motion_reg <= lm_new;
                    peak_a_reg      <= pa_new;
                    peak_g_reg      <= pg_new;
                end
            end
        end
    end

    // report building
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            now_reg <= s_payload.time_ms;
        end
        if (state_reg == ST_DECIDE) begin
            res_reg.severity_tenths <= '0;
            res_reg.severity_class  <= iies_pkg::CLASS_MINOR;
            if (!active_reg) begin
                res_reg.event_kind  <= iies_pkg::KIND_STARTED;
                res_reg.duration_ms <= '0;
                res_reg.peak_accel  <= adelta;
                res_reg.peak_gyro   <= gmag;
            end else begin
                res_reg.event_kind  <= score_go ? iies_pkg::KIND_COMPLETE
                                                : iies_pkg::KIND_IGNORED;
                res_reg.duration_ms <= dur;
                res_reg.peak_accel  <= pa_new;
                res_reg.peak_gyro   <= pg_new;
            end
        end else if ((state_reg == ST_SCORE) && score.done) begin
            res_reg.severity_tenths <= score.tenths;
            res_reg.severity_class  <= score.sclass;
        end
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // both lanes finish together
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        a_lane.done == g_lane.done)
        else $error("magnitude lanes out of step");

    // a transfer always starts the lanes
    a_xfer_to_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_LANE))
        else $error("sample transfer did not enter lane phase");

    // severity stays in range
    a_sev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.severity_tenths <= iies_pkg::SEV_MAX))
        else $error("severity out of range");

    // start reports carry no duration or score
    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.event_kind == iies_pkg::KIND_STARTED)) |->
        ((m_data_reg.duration_ms == '0) && (m_data_reg.severity_tenths == '0)))
        else $error("start report carries duration or severity");

    // the scorer only runs while an event closes
    a_score_only_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        score_go |=> (state_reg == ST_SCORE) && !active_reg)
        else $error("scorer launched outside event close");

endmodule
